[src/supply_bus_position_sensor_filter_assert.svh]
// Assertion macros for the supply, bus and position sensor filter
`ifndef SUPPLY_BUS_POSITION_SENSOR_FILTER_ASSERT_SVH
`define SUPPLY_BUS_POSITION_SENSOR_FILTER_ASSERT_SVH

// same-cycle implication
`define SBPSF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbpsf assertion failed");

// next-cycle implication
`define SBPSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbpsf assertion failed");

`endif

[src/sbpsf_pkg.sv]
// Package: shared types and constants of the supply bus position sensor filter
`timescale 1ns / 1ps
package sbpsf_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BUS_DIV  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POS_GAIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POS_LEN  = 2'd2;

  localparam logic [31:0] SUPPLY_NUMERATOR = 32'd5079040;
  localparam logic [11:0] SUPPLY_SAT_REF   = 12'd78;
  localparam int unsigned POS_SHIFT        = 11;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

[src/sbpsf_div.sv]
// Iterative 16-step restoring divider, quotient known to fit 16 bits
`timescale 1ns / 1ps
module sbpsf_div
  import sbpsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [16:0] rem_shift;
  logic [16:0] rem_sub;
  logic        ge;

  assign rem_shift = {rem, quo[15]};
  assign rem_sub   = rem_shift - {1'b0, dvs};
  assign ge        = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= req.dividend[31:16];
        quo  <= req.dividend[15:0];
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? rem_sub[15:0] : rem_shift[15:0];
        quo <= {quo[14:0], ge};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[src/supply_bus_position_sensor_filter.sv]
// Top level: supply, bus, temperature and position filter on one shared divider
// Input channel s_*: one transfer carries a set of four 12-bit conversions.
// Output channel m_*: one transfer per input set with the updated averages.
// Configuration: cfg_we writes cfg_data into the register cfg_index
// (0 bus divisor, 1 position gain, 2 position filter length); write only
// while the block is idle.
// One set at a time: s_tready is high only when the sequencer is idle.
// A set runs through three multiplies on one 18x17 multiplier and up to
// three divisions on one 16-step iterative divider.
// A division is bypassed when the supply or bus saturates, and the position
// division is bypassed when the position filter is off.
// The result sits in an output register; the next set is taken while it
// waits, and the final update holds until m_tready frees that register.
// Reset (rst, synchronous) restores the register defaults, clears the
// averages and makes the first set load them directly.
`timescale 1ns / 1ps
`include "supply_bus_position_sensor_filter_assert.svh"
module supply_bus_position_sensor_filter
  import sbpsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // raw_bus, raw_position, raw_temperature, raw_reference
  input  logic [47:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // supply_mv, bus_mv, temperature_count, position_value, zero pad
  output logic [63:0]            m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MPOS, ST_SUP, ST_WSUP, ST_MBUS, ST_BDIV,
    ST_WBUS, ST_MAVG, ST_PDIV, ST_WPOS, ST_UPD
  } state_t;

  state_t state;

  logic [15:0] bus_div;
  logic [13:0] pos_gain;
  logic [6:0]  pos_len;

  logic [11:0] raw_bus;
  logic [11:0] raw_pos;
  logic [11:0] raw_temp;
  logic [11:0] raw_ref;

  logic               primed;
  logic [15:0]        supply_avg;
  logic [15:0]        bus_avg;
  logic [11:0]        temp_avg;
  logic signed [15:0] pos_avg;

  logic [15:0]        supply;
  logic [15:0]        bus;
  logic signed [15:0] pos;
  logic signed [15:0] pos_new;
  logic               pos_neg;

  logic signed [17:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [34:0] mprod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0]        bus_dvs;
  logic               bus_sat;
  logic signed [16:0] pos_calc;
  logic signed [23:0] pos_num;
  logic [23:0]        pos_mag;
  logic               pos_filt;
  logic [17:0]        supply_blend;
  logic [17:0]        bus_blend;
  logic [13:0]        temp_blend;
  logic               out_free;

  sbpsf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_div  <= 16'd1;
      pos_gain <= '0;
      pos_len  <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUS_DIV:  bus_div  <= cfg_data;
        REG_POS_GAIN: pos_gain <= cfg_data[13:0];
        REG_POS_LEN:  pos_len  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign bus_dvs  = (bus_div == 16'd0) ? 16'd1 : bus_div;
  assign bus_sat  = {4'd0, mprod[27:16]} >= bus_dvs;
  assign pos_calc = $signed({2'b00, mprod[POS_SHIFT+14:POS_SHIFT]})
                  - $signed({3'b000, pos_gain});
  assign pos_num  = mprod[23:0] + {{8{pos[15]}}, pos} + {18'd0, pos_len[6:1]};
  assign pos_mag  = pos_num[23] ? 24'(-pos_num) : pos_num;
  assign pos_filt = primed && (pos_len > 7'd1);

  assign supply_blend = {2'b00, supply_avg} + {1'b0, supply_avg, 1'b0} + {2'b00, supply};
  assign bus_blend    = {2'b00, bus_avg} + {1'b0, bus_avg, 1'b0} + {2'b00, bus};
  assign temp_blend   = {2'b00, temp_avg} + {1'b0, temp_avg, 1'b0} + {2'b00, raw_temp};

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MPOS: begin
        mul_a = $signed({6'd0, raw_pos});
        mul_b = $signed({3'd0, pos_gain});
      end
      ST_MBUS: begin
        mul_a = $signed({6'd0, raw_bus});
        mul_b = $signed({1'b0, supply});
      end
      ST_MAVG: begin
        mul_a = {{2{pos_avg[15]}}, pos_avg};
        mul_b = $signed({10'd0, 7'(pos_len - 7'd1)});
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req = '0;
    unique case (state)
      ST_SUP: begin
        div_req.start    = raw_ref >= SUPPLY_SAT_REF;
        div_req.dividend = SUPPLY_NUMERATOR;
        div_req.divisor  = {4'd0, raw_ref};
      end
      ST_BDIV: begin
        div_req.start    = !bus_sat;
        div_req.dividend = {4'd0, mprod[27:0]};
        div_req.divisor  = bus_dvs;
      end
      ST_PDIV: begin
        div_req.start    = pos_filt;
        div_req.dividend = {8'd0, pos_mag};
        div_req.divisor  = {9'd0, pos_len};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      primed     <= 1'b0;
      supply_avg <= '0;
      bus_avg    <= '0;
      temp_avg   <= '0;
      pos_avg    <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_UPD) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            raw_bus  <= s_tdata[11:0];
            raw_pos  <= s_tdata[23:12];
            raw_temp <= s_tdata[35:24];
            raw_ref  <= s_tdata[47:36];
            state    <= ST_MPOS;
          end
        end
        ST_MPOS: begin
          mprod <= mul_a * mul_b;
          state <= ST_SUP;
        end
        ST_SUP: begin
          pos <= pos_calc[15:0];
          if (raw_ref >= SUPPLY_SAT_REF) begin
            state <= ST_WSUP;
          end else begin
            supply <= 16'hFFFF;
            state  <= ST_MBUS;
          end
        end
        ST_WSUP: begin
          if (div_rsp.done) begin
            supply <= div_rsp.quotient;
            state  <= ST_MBUS;
          end
        end
        ST_MBUS: begin
          mprod <= mul_a * mul_b;
          state <= ST_BDIV;
        end
        ST_BDIV: begin
          if (bus_sat) begin
            bus   <= 16'hFFFF;
            state <= ST_MAVG;
          end else begin
            state <= ST_WBUS;
          end
        end
        ST_WBUS: begin
          if (div_rsp.done) begin
            bus   <= div_rsp.quotient;
            state <= ST_MAVG;
          end
        end
        ST_MAVG: begin
          mprod <= mul_a * mul_b;
          state <= ST_PDIV;
        end
        ST_PDIV: begin
          pos_neg <= pos_num[23];
          if (pos_filt) begin
            state <= ST_WPOS;
          end else begin
            pos_new <= pos;
            state   <= ST_UPD;
          end
        end
        ST_WPOS: begin
          if (div_rsp.done) begin
            pos_new <= pos_neg ? $signed(16'(-div_rsp.quotient))
                               : $signed(div_rsp.quotient);
            state   <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            if (primed) begin
              supply_avg <= supply_blend[17:2];
              bus_avg    <= bus_blend[17:2];
              temp_avg   <= temp_blend[13:2];
            end else begin
              supply_avg <= supply;
              bus_avg    <= bus;
              temp_avg   <= raw_temp;
            end
            pos_avg  <= pos_new;
            primed   <= 1'b1;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {5'd0, pos_avg[14:0], temp_avg, bus_avg, supply_avg};

  `SBPSF_ASSERT_NOW(a_div_busy_in_wait, clk, rst, div_rsp.busy,
    state == ST_WSUP || state == ST_WBUS || state == ST_WPOS)
  `SBPSF_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `SBPSF_ASSERT_NEXT(a_primed_sticks, clk, rst, primed, primed)

endmodule
